// File: sv/button_and_tap_event_classifier_macros.svh
// ----------------------------------------------------------------------------
// Button and tap event classifier assertion macros
// Concurrent assertion helpers used by the classifier top level.
// ----------------------------------------------------------------------------
`ifndef BUTTON_AND_TAP_EVENT_CLASSIFIER_MACROS_SVH
`define BUTTON_AND_TAP_EVENT_CLASSIFIER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Same-cycle implication, checked at every rising edge outside reset.
`define BEC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("classifier assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define BEC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("classifier assertion failed");

`else

`define BEC_ASSERT_NOW(label, ante, cons)
`define BEC_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// File: sv/bec_pkg.sv
// ----------------------------------------------------------------------------
// Button and tap event classifier package
// Payload and configuration types, register indexes and reset values.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bec_pkg;

  localparam int unsigned TimeW  = 32;
  localparam int unsigned CoordW = 12;
  localparam int unsigned MsW    = 16;
  localparam int unsigned EnW    = 5;
  localparam int unsigned IdxW   = 3;
  localparam int unsigned DataW  = 16;

  // Bit positions in source_enable
  localparam int unsigned EnButton1 = 0;
  localparam int unsigned EnButton2 = 1;
  localparam int unsigned EnButton3 = 2;
  localparam int unsigned EnPower   = 3;
  localparam int unsigned EnTouch   = 4;

  localparam logic [MsW-1:0]    ShortPressMinReset = 16'd40;
  localparam logic [MsW-1:0]    ShortPressMaxReset = 16'd800;
  localparam logic [MsW-1:0]    HoldAbortReset     = 16'd4000;
  localparam logic [MsW-1:0]    TapMaxMsReset      = 16'd800;
  localparam logic [CoordW-1:0] TapMaxMoveReset    = 12'd28;
  localparam logic [EnW-1:0]    SourceEnableReset  = 5'd31;

  typedef enum logic [IdxW-1:0] {
    REG_SHORT_PRESS_MIN = 3'd0,
    REG_SHORT_PRESS_MAX = 3'd1,
    REG_HOLD_ABORT      = 3'd2,
    REG_TAP_MAX_MS      = 3'd3,
    REG_TAP_MAX_MOVE    = 3'd4,
    REG_SOURCE_ENABLE   = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic [TimeW-1:0]  now_ms;
    logic              button1_level;
    logic              button2_level;
    logic              button3_level;
    logic              power_pressed;
    logic              touch_down;
    logic [CoordW-1:0] touch_x;
    logic [CoordW-1:0] touch_y;
  } sample_t;

  typedef struct packed {
    logic              button1_event;
    logic              button2_event;
    logic              button3_event;
    logic              tap_event;
    logic [CoordW-1:0] tap_x;
    logic [CoordW-1:0] tap_y;
  } result_t;

  typedef struct packed {
    logic [MsW-1:0]    short_press_min_ms;
    logic [MsW-1:0]    short_press_max_ms;
    logic [MsW-1:0]    hold_abort_ms;
    logic [MsW-1:0]    tap_max_ms;
    logic [CoordW-1:0] tap_max_move;
    logic [EnW-1:0]    source_enable;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/button_and_tap_event_classifier.sv
// ----------------------------------------------------------------------------
// Button and tap event classifier
// Turns poll samples of buttons, power key and touch panel into events.
// ----------------------------------------------------------------------------
// Takes one poll request per clock while sample_stall is low and returns
// exactly one result request per sample, in order: the sample lands in an
// input register, the event logic evaluates it combinationally against the
// stored button, power and touch history, and the answer is held in a result
// register until it is taken. The input and result registers together form
// a two-entry pipeline, so a new sample is accepted every cycle as long as
// the result side keeps draining; sample_stall rises only while both
// registers are full and result_stall is high.
// Configuration writes are always accepted (cfg_ready is tied high) and
// should be issued only while no sample is in flight.
`timescale 1ns / 1ps
`default_nettype none

`include "button_and_tap_event_classifier_macros.svh"

module button_and_tap_event_classifier (
  input  wire logic                      clk,
  input  wire logic                      rst,
  // Poll sample channel
  input  wire logic                      sample_valid,
  output logic                           sample_stall,
  input  wire bec_pkg::sample_t          sample,
  // Result channel
  output logic                           result_valid,
  input  wire logic                      result_stall,
  output bec_pkg::result_t               result,
  // Configuration write channel
  input  wire logic                      cfg_valid,
  output logic                           cfg_ready,
  input  wire logic [bec_pkg::IdxW-1:0]   cfg_index,
  input  wire logic [bec_pkg::DataW-1:0]  cfg_data
);

  bec_pkg::cfg_t    cfg;
  bec_pkg::sample_t s1_sample;
  bec_pkg::result_t core_result;
  logic             s1_valid;
  logic             advance;
  logic             fire;

  assign cfg_ready = 1'b1;

  // Result register frees up when empty or taken this cycle
  assign advance      = !result_valid || !result_stall;
  assign fire         = s1_valid && advance;
  // Hold the sample side only while the input register cannot move on
  assign sample_stall = s1_valid && !advance;

  bec_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_valid && cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (!sample_stall) begin
      s1_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      s1_sample <= sample;
    end
  end

  bec_core u_core (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .sample (s1_sample),
    .fire   (fire),
    .result (core_result)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (advance) begin
      result_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_result;
    end
  end

  // Stall toward the sample side only with a full, blocked result register
  `BEC_ASSERT_NOW(a_stall_cause, sample_stall, s1_valid && result_valid && result_stall)
  // A sample that moves on always shows up as a result next cycle
  `BEC_ASSERT_NEXT(a_fire_delivers, fire, result_valid)
  // Tap coordinates stay zero when no tap is reported
  `BEC_ASSERT_NOW(a_tap_zero, result_valid && !result.tap_event,
    result.tap_x == '0 && result.tap_y == '0)

endmodule

`default_nettype wire

// File: sv/bec_cfg.sv
// ----------------------------------------------------------------------------
// Classifier configuration registers
// Holds the six configuration registers, written through the index port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bec_cfg (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     cfg_write,
  input  wire logic [bec_pkg::IdxW-1:0]  cfg_index,
  input  wire logic [bec_pkg::DataW-1:0] cfg_data,
  output bec_pkg::cfg_t                 cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_press_min_ms <= bec_pkg::ShortPressMinReset;
      cfg.short_press_max_ms <= bec_pkg::ShortPressMaxReset;
      cfg.hold_abort_ms      <= bec_pkg::HoldAbortReset;
      cfg.tap_max_ms         <= bec_pkg::TapMaxMsReset;
      cfg.tap_max_move       <= bec_pkg::TapMaxMoveReset;
      cfg.source_enable      <= bec_pkg::SourceEnableReset;
    end else if (cfg_write) begin
      // Unknown indexes drop silently
      case (bec_pkg::reg_index_t'(cfg_index))
        bec_pkg::REG_SHORT_PRESS_MIN: cfg.short_press_min_ms <= cfg_data;
        bec_pkg::REG_SHORT_PRESS_MAX: cfg.short_press_max_ms <= cfg_data;
        bec_pkg::REG_HOLD_ABORT:      cfg.hold_abort_ms      <= cfg_data;
        bec_pkg::REG_TAP_MAX_MS:      cfg.tap_max_ms         <= cfg_data;
        bec_pkg::REG_TAP_MAX_MOVE:
          cfg.tap_max_move <= cfg_data[bec_pkg::CoordW-1:0];
        bec_pkg::REG_SOURCE_ENABLE:
          cfg.source_enable <= cfg_data[bec_pkg::EnW-1:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// File: sv/bec_core.sv
// ----------------------------------------------------------------------------
// Classifier event logic
// Tracks button, power and touch history and forms one result per sample.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bec_core (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire bec_pkg::cfg_t   cfg,
  input  wire bec_pkg::sample_t sample,
  input  wire logic            fire,
  output bec_pkg::result_t     result
);

  logic                      button1_prev, button1_prev_next;
  logic                      button2_prev, button2_prev_next;
  logic                      button3_prev, button3_prev_next;
  logic                      power_held, power_held_next;
  logic [bec_pkg::TimeW-1:0]  power_press_time;
  logic                      touch_active, touch_active_next;
  logic [bec_pkg::CoordW-1:0] touch_first_x, touch_first_y;
  logic [bec_pkg::CoordW-1:0] touch_latest_x, touch_latest_y;
  logic [bec_pkg::TimeW-1:0]  touch_begin_time;

  logic                      en1, en2, en3, en_touch, pwr;
  logic                      press_start, touch_start;
  logic [bec_pkg::TimeW-1:0]  held, dur;
  logic [bec_pkg::CoordW-1:0] dx, dy;
  logic                      short_press, tap;

  assign en1      = cfg.source_enable[bec_pkg::EnButton1];
  assign en2      = cfg.source_enable[bec_pkg::EnButton2];
  assign en3      = cfg.source_enable[bec_pkg::EnButton3];
  assign en_touch = cfg.source_enable[bec_pkg::EnTouch];
  assign pwr      = sample.power_pressed & cfg.source_enable[bec_pkg::EnPower];

  // Elapsed times wrap modulo 2^32
  assign held = sample.now_ms - power_press_time;
  assign dur  = sample.now_ms - touch_begin_time;

  assign dx = (touch_latest_x >= touch_first_x) ? touch_latest_x - touch_first_x
                                                : touch_first_x - touch_latest_x;
  assign dy = (touch_latest_y >= touch_first_y) ? touch_latest_y - touch_first_y
                                                : touch_first_y - touch_latest_y;

  always_comb begin
    button1_prev_next = en1 ? sample.button1_level : button1_prev;
    button2_prev_next = en2 ? sample.button2_level : button2_prev;
    button3_prev_next = en3 ? sample.button3_level : button3_prev;

    press_start     = 1'b0;
    short_press     = 1'b0;
    power_held_next = power_held;
    if (pwr && !power_held) begin
      power_held_next = 1'b1;
      press_start     = 1'b1;
    end else if (!pwr && power_held) begin
      power_held_next = 1'b0;
      short_press = (held >= {16'd0, cfg.short_press_min_ms}) &&
                    (held <  {16'd0, cfg.short_press_max_ms});
    end else if (pwr && power_held && (held > {16'd0, cfg.hold_abort_ms})) begin
      // Long hold: cancel the press with no event
      power_held_next = 1'b0;
    end

    touch_start       = 1'b0;
    tap               = 1'b0;
    touch_active_next = touch_active;
    if (en_touch) begin
      if (sample.touch_down) begin
        touch_active_next = 1'b1;
        touch_start       = !touch_active;
      end else if (touch_active) begin
        touch_active_next = 1'b0;
        tap = (dur < {16'd0, cfg.tap_max_ms}) &&
              (dx < cfg.tap_max_move) && (dy < cfg.tap_max_move);
      end
    end

    result.button1_event = en1 && button1_prev && !sample.button1_level;
    result.button2_event = (en2 && button2_prev && !sample.button2_level) || short_press;
    result.button3_event = en3 && button3_prev && !sample.button3_level;
    result.tap_event     = tap;
    result.tap_x         = tap ? touch_first_x : '0;
    result.tap_y         = tap ? touch_first_y : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      button1_prev <= 1'b1;
      button2_prev <= 1'b1;
      button3_prev <= 1'b1;
      power_held   <= 1'b0;
      touch_active <= 1'b0;
    end else if (fire) begin
      button1_prev <= button1_prev_next;
      button2_prev <= button2_prev_next;
      button3_prev <= button3_prev_next;
      power_held   <= power_held_next;
      touch_active <= touch_active_next;
    end
  end

  // Timestamps and coordinates are read only while their flag is set
  always_ff @(posedge clk) begin
    if (fire) begin
      if (press_start) begin
        power_press_time <= sample.now_ms;
      end
      if (touch_start) begin
        touch_first_x    <= sample.touch_x;
        touch_first_y    <= sample.touch_y;
        touch_begin_time <= sample.now_ms;
      end
      if (en_touch && sample.touch_down) begin
        touch_latest_x <= sample.touch_x;
        touch_latest_y <= sample.touch_y;
      end
    end
  end

endmodule

`default_nettype wire

// File: tb/button_and_tap_event_checker.sv
// ----------------------------------------------------------------------------
// Button and tap event checker
// Watches the poll, result and register channels of the classifier, keeps
// its own model of the button, power and touch history, and compares every
// result request with the prediction for the oldest accepted poll.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_and_tap_event_checker (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      sample_valid,
  input  logic                      sample_stall,
  input  bec_pkg::sample_t          sample,
  input  logic                      result_valid,
  input  logic                      result_stall,
  input  bec_pkg::result_t          result,
  input  logic                      cfg_valid,
  input  logic                      cfg_ready,
  input  logic [bec_pkg::IdxW-1:0]  cfg_index,
  input  logic [bec_pkg::DataW-1:0] cfg_data,
  output int                        mismatches,
  output int                        outstanding
);

  import bec_pkg::*;

  typedef struct packed {
    logic              b1_last;
    logic              b2_last;
    logic              b3_last;
    logic              power_down;
    logic [TimeW-1:0]  power_since;
    logic              touching;
    logic [CoordW-1:0] first_x;
    logic [CoordW-1:0] first_y;
    logic [CoordW-1:0] last_x;
    logic [CoordW-1:0] last_y;
    logic [TimeW-1:0]  touch_since;
  } history_t;

  cfg_t     settings;
  history_t history;
  result_t  expected_events[$];
  result_t  want;

  function automatic logic [CoordW-1:0] spread(input logic [CoordW-1:0] a,
                                               input logic [CoordW-1:0] b);
    return (a >= b) ? a - b : b - a;
  endfunction

  // Advance the history by one poll and return the events it raises.
  function automatic result_t classify_poll(input sample_t s);
    result_t          r;
    logic             pwr;
    logic [TimeW-1:0] held;
    logic [TimeW-1:0] lasted;
    r = '0;
    if (settings.source_enable[EnButton1]) begin
      r.button1_event = history.b1_last & ~s.button1_level;
      history.b1_last = s.button1_level;
    end
    if (settings.source_enable[EnButton2]) begin
      r.button2_event = history.b2_last & ~s.button2_level;
      history.b2_last = s.button2_level;
    end
    if (settings.source_enable[EnButton3]) begin
      r.button3_event = history.b3_last & ~s.button3_level;
      history.b3_last = s.button3_level;
    end

    // A disabled power key reads as released.
    pwr  = s.power_pressed & settings.source_enable[EnPower];
    held = s.now_ms - history.power_since;
    if (pwr && !history.power_down) begin
      history.power_down  = 1'b1;
      history.power_since = s.now_ms;
    end else if (!pwr && history.power_down) begin
      history.power_down = 1'b0;
      if (held >= TimeW'(settings.short_press_min_ms) &&
          held <  TimeW'(settings.short_press_max_ms)) begin
        r.button2_event = 1'b1;
      end
    end else if (pwr && history.power_down && held > TimeW'(settings.hold_abort_ms)) begin
      history.power_down = 1'b0;
    end

    if (settings.source_enable[EnTouch]) begin
      if (s.touch_down) begin
        if (!history.touching) begin
          history.touching    = 1'b1;
          history.first_x     = s.touch_x;
          history.first_y     = s.touch_y;
          history.touch_since = s.now_ms;
        end
        history.last_x = s.touch_x;
        history.last_y = s.touch_y;
      end else if (history.touching) begin
        history.touching = 1'b0;
        lasted = s.now_ms - history.touch_since;
        if (lasted < TimeW'(settings.tap_max_ms) &&
            spread(history.last_x, history.first_x) < settings.tap_max_move &&
            spread(history.last_y, history.first_y) < settings.tap_max_move) begin
          r.tap_event = 1'b1;
          r.tap_x     = history.first_x;
          r.tap_y     = history.first_y;
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      settings = '{ShortPressMinReset, ShortPressMaxReset, HoldAbortReset,
                   TapMaxMsReset, TapMaxMoveReset, SourceEnableReset};
      history  = '0;
      history.b1_last = 1'b1;
      history.b2_last = 1'b1;
      history.b3_last = 1'b1;
      expected_events.delete();
      mismatches = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_SHORT_PRESS_MIN: settings.short_press_min_ms = cfg_data[MsW-1:0];
          REG_SHORT_PRESS_MAX: settings.short_press_max_ms = cfg_data[MsW-1:0];
          REG_HOLD_ABORT:      settings.hold_abort_ms      = cfg_data[MsW-1:0];
          REG_TAP_MAX_MS:      settings.tap_max_ms         = cfg_data[MsW-1:0];
          REG_TAP_MAX_MOVE:    settings.tap_max_move       = cfg_data[CoordW-1:0];
          REG_SOURCE_ENABLE:   settings.source_enable      = cfg_data[EnW-1:0];
          default: ;
        endcase
      end

      if (result_valid && !result_stall) begin
        if (expected_events.size() == 0) begin
          $error("result request with no poll waiting for it");
          mismatches++;
        end else begin
          want = expected_events.pop_front();
          if (result.button1_event !== want.button1_event) begin
            $error("button1_event: expected %0d, got %0d",
                   want.button1_event, result.button1_event);
            mismatches++;
          end
          if (result.button2_event !== want.button2_event) begin
            $error("button2_event: expected %0d, got %0d",
                   want.button2_event, result.button2_event);
            mismatches++;
          end
          if (result.button3_event !== want.button3_event) begin
            $error("button3_event: expected %0d, got %0d",
                   want.button3_event, result.button3_event);
            mismatches++;
          end
          if (result.tap_event !== want.tap_event) begin
            $error("tap_event: expected %0d, got %0d", want.tap_event, result.tap_event);
            mismatches++;
          end
          if (result.tap_x !== want.tap_x) begin
            $error("tap_x: expected %0d, got %0d", want.tap_x, result.tap_x);
            mismatches++;
          end
          if (result.tap_y !== want.tap_y) begin
            $error("tap_y: expected %0d, got %0d", want.tap_y, result.tap_y);
            mismatches++;
          end
        end
      end

      if (sample_valid && !sample_stall) begin
        expected_events.push_back(classify_poll(sample));
      end
    end
    outstanding = expected_events.size();
  end

endmodule

// File: tb/button_and_tap_event_classifier_test.sv
// ----------------------------------------------------------------------------
// Button and tap event classifier testbench
// Drives poll requests and register writes into the classifier, stalls the
// result side at random, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module button_and_tap_event_classifier_test;

  import bec_pkg::*;

  localparam int NumPhases     = 8;
  localparam int PollsPerPhase = 118;
  localparam int QuietLimit    = 2000;
  localparam int CoordMax      = (1 << CoordW) - 1;

  logic              clk;
  logic              rst;
  logic              sample_valid;
  logic              sample_stall;
  sample_t           sample;
  logic              result_valid;
  logic              result_stall;
  result_t           result;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IdxW-1:0]   cfg_index;
  logic [DataW-1:0]  cfg_data;
  int                mismatches;
  int                outstanding;

  // Stimulus state: the time base of the poll stream, the current button
  // levels, the settings last written, and the idle densities per side.
  logic [TimeW-1:0]  clock_ms;
  logic [2:0]        buttons;
  cfg_t              cur;
  int                gap_pct;
  int                stall_pct;
  int unsigned       sent;
  int                quiet_cycles;

  button_and_tap_event_classifier dut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  button_and_tap_event_checker u_checker (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .mismatches   (mismatches),
    .outstanding  (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Stall the result side in bursts; stall_pct sets how often a burst
  // starts, and zero gives a stretch with no stalls at all.
  initial begin
    result_stall = 1'b0;
    forever begin
      @(negedge clk);
      if ($urandom_range(0, 99) < stall_pct) begin
        result_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(negedge clk);
        result_stall <= 1'b0;
      end
    end
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst) begin
      quiet_cycles <= 0;
    end else if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
                 (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Drive one poll request at the falling edge, optionally after an idle
  // burst, and hold it until the block takes it.
  task automatic send(input logic [2:0] levels, input logic pwr, input logic down,
                      input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    sample_t s;
    int      gap;
    s.now_ms        = clock_ms;
    s.button1_level = levels[0];
    s.button2_level = levels[1];
    s.button3_level = levels[2];
    s.power_pressed = pwr;
    s.touch_down    = down;
    s.touch_x       = x;
    s.touch_y       = y;
    gap = ($urandom_range(0, 99) < gap_pct) ? $urandom_range(1, 8) : 0;
    @(negedge clk);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample_valid <= 1'b1;
    sample       <= s;
    do @(posedge clk); while (sample_stall);
    sent++;
  endtask

  // Directed poll with explicit button levels.
  task automatic put(input logic [TimeW-1:0] at, input logic [2:0] levels,
                     input logic pwr, input logic down,
                     input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    clock_ms = at;
    send(levels, pwr, down, x, y);
  endtask

  // Random-stream poll: advance time and let the buttons chatter.
  task automatic poll_at(input logic [TimeW-1:0] at, input logic pwr, input logic down,
                         input logic [CoordW-1:0] x, input logic [CoordW-1:0] y);
    clock_ms = at;
    buttons  = buttons ^ (3'($urandom) & 3'($urandom));
    send(buttons, pwr, down, x, y);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic settle();
    @(negedge clk);
    sample_valid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
  endtask

  task automatic write_reg(input logic [IdxW-1:0] idx, input logic [DataW-1:0] data);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Write every register; junk in the unused upper bits must be masked off,
  // and a write past the last register must be ignored.
  task automatic apply_settings(input cfg_t c);
    logic [DataW-1:0] data;
    write_reg(REG_SHORT_PRESS_MIN, c.short_press_min_ms);
    write_reg(REG_SHORT_PRESS_MAX, c.short_press_max_ms);
    write_reg(REG_HOLD_ABORT, c.hold_abort_ms);
    write_reg(REG_TAP_MAX_MS, c.tap_max_ms);
    data = DataW'($urandom);
    data[CoordW-1:0] = c.tap_max_move;
    write_reg(REG_TAP_MAX_MOVE, data);
    data = DataW'($urandom);
    data[EnW-1:0] = c.source_enable;
    write_reg(REG_SOURCE_ENABLE, data);
    if ($urandom_range(0, 1)) begin
      write_reg(IdxW'(REG_SOURCE_ENABLE + 1 + $urandom_range(0, 1)), DataW'($urandom));
    end
    cur = c;
  endtask

  // Movement for one axis of a gesture, half the time at or just under the tap limit.
  function automatic int unsigned reach();
    case ($urandom_range(0, 3))
      0:       return cur.tap_max_move;
      1:       return (cur.tap_max_move == 0) ? 0 : cur.tap_max_move - 1;
      2:       return $urandom_range(0, 64);
      default: return $urandom_range(0, CoordMax);
    endcase
  endfunction

  function automatic logic [CoordW-1:0] nudge(input logic [CoordW-1:0] c,
                                              input int unsigned r);
    int v;
    v = $urandom_range(0, 1) ? int'(c) + int'(r) : int'(c) - int'(r);
    if (v < 0) v = 0;
    else if (v > CoordMax) v = CoordMax;
    return CoordW'(v);
  endfunction

  // Power key press and release with a hold that often straddles one of the
  // thresholds; now and then keep holding past the release point so the
  // abort rule gets its chance first.
  task automatic power_press();
    int unsigned      hold;
    logic [TimeW-1:0] start;
    logic             keep;
    int               k;
    case ($urandom_range(0, 4))
      0:       hold = cur.short_press_min_ms;
      1:       hold = cur.short_press_max_ms;
      2:       hold = cur.hold_abort_ms;
      3:       hold = $urandom_range(0, 9000);
      default: hold = $urandom_range(0, 70000);
    endcase
    hold = hold + $urandom_range(0, 2) - 1;
    keep = ($urandom_range(0, 3) == 0);
    poll_at(clock_ms + $urandom_range(1, 30), 1'b1, 1'b0, '0, '0);
    start = clock_ms;
    k = $urandom_range(0, 2);
    for (int i = 1; i <= k; i++) begin
      poll_at(start + TimeW'(longint'(hold) * i / (k + 1)), 1'b1, 1'b0, '0, '0);
    end
    poll_at(start + hold, keep, 1'b0, '0, '0);
    if (keep) begin
      poll_at(clock_ms + $urandom_range(1, 10), 1'b0, 1'b0, '0, '0);
    end
  endtask

  // Touch gesture: press, wander, settle at the final point, release.
  task automatic touch_gesture();
    logic [CoordW-1:0] x0;
    logic [CoordW-1:0] y0;
    logic [TimeW-1:0]  start;
    int unsigned       dur;
    int                k;
    x0 = CoordW'($urandom_range(0, CoordMax));
    y0 = CoordW'($urandom_range(0, CoordMax));
    case ($urandom_range(0, 3))
      0:       dur = cur.tap_max_ms;
      1:       dur = cur.tap_max_ms - 1;
      2:       dur = $urandom_range(0, 2000);
      default: dur = $urandom_range(0, 200);
    endcase
    poll_at(clock_ms + $urandom_range(1, 30), 1'b0, 1'b1, x0, y0);
    start = clock_ms;
    k = $urandom_range(0, 2);
    for (int i = 1; i <= k; i++) begin
      poll_at(start + TimeW'(longint'(dur) * i / (2 * (k + 1))), 1'b0, 1'b1,
              nudge(x0, $urandom_range(0, 64)), nudge(y0, $urandom_range(0, 64)));
    end
    poll_at(start + dur / 2, 1'b0, 1'b1, nudge(x0, reach()), nudge(y0, reach()));
    // Coordinates on the release are meaningless; randomize them fully.
    poll_at(start + dur, 1'b0, 1'b0,
            CoordW'($urandom_range(0, CoordMax)), CoordW'($urandom_range(0, CoordMax)));
  endtask

  initial begin
    cfg_t        c;
    int unsigned phase_end;

    rst          = 1'b1;
    sample_valid = 1'b0;
    sample       = '0;
    cfg_valid    = 1'b0;
    cfg_index    = '0;
    cfg_data     = '0;
    clock_ms     = '0;
    buttons      = '1;
    sent         = 0;
    gap_pct      = 20;
    stall_pct    = 20;
    cur = '{ShortPressMinReset, ShortPressMaxReset, HoldAbortReset,
            TapMaxMsReset, TapMaxMoveReset, SourceEnableReset};

    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // Directed part, run on the reset settings.
    // Press edges on all three buttons, then hold and release.
    put(100, 3'b111, 1'b0, 1'b0, '0, '0);
    put(110, 3'b000, 1'b0, 1'b0, '0, '0);
    put(120, 3'b000, 1'b0, 1'b0, '0, '0);
    put(130, 3'b111, 1'b0, 1'b0, '0, '0);
    // Short press exactly at the minimum, just under the maximum, at the maximum.
    put(1000, 3'b111, 1'b1, 1'b0, '0, '0);
    put(1040, 3'b111, 1'b0, 1'b0, '0, '0);
    put(2000, 3'b111, 1'b1, 1'b0, '0, '0);
    put(2799, 3'b111, 1'b0, 1'b0, '0, '0);
    put(3000, 3'b111, 1'b1, 1'b0, '0, '0);
    put(3800, 3'b111, 1'b0, 1'b0, '0, '0);
    // Hold past the abort limit, then release: no event either time.
    put(5000, 3'b111, 1'b1, 1'b0, '0, '0);
    put(9001, 3'b111, 1'b1, 1'b0, '0, '0);
    put(9010, 3'b111, 1'b0, 1'b0, '0, '0);
    // Short press across the wrap of the millisecond counter.
    put(32'hFFFF_FFE0, 3'b111, 1'b1, 1'b0, '0, '0);
    put(32'h0000_0020, 3'b111, 1'b0, 1'b0, '0, '0);
    // Tap at the corner, moved one short of the limit.
    put(100, 3'b111, 1'b0, 1'b1, CoordW'(CoordMax), '0);
    put(300, 3'b111, 1'b0, 1'b1, CoordW'(CoordMax - 27), 12'd27);
    put(899, 3'b111, 1'b0, 1'b0, 12'hABC, 12'h543);
    // Movement right at the limit: no tap.
    put(1000, 3'b111, 1'b0, 1'b1, '0, CoordW'(CoordMax));
    put(1100, 3'b111, 1'b0, 1'b1, '0, CoordW'(CoordMax - 28));
    put(1200, 3'b111, 1'b0, 1'b0, '0, '0);
    // Duration right at the limit: no tap.
    put(2000, 3'b111, 1'b0, 1'b1, 12'd2048, 12'd2048);
    put(2800, 3'b111, 1'b0, 1'b0, 12'd2048, 12'd2048);

    // Only the power key enabled: buttons and touch ignored, yet a short
    // power press still raises the button 2 event.
    settle();
    write_reg(REG_SOURCE_ENABLE, DataW'(1 << EnPower));
    put(3000, 3'b000, 1'b1, 1'b1, 12'd5, 12'd5);
    put(3100, 3'b111, 1'b0, 1'b0, 12'd5, 12'd5);
    put(3200, 3'b000, 1'b1, 1'b0, '0, '0);
    // Disable the power key while it is held: read as a release.
    settle();
    write_reg(REG_SOURCE_ENABLE, '0);
    put(3300, 3'b000, 1'b1, 1'b0, '0, '0);

    // Random phases, each under its own settings and idle densities.
    for (int phase = 0; phase < NumPhases; phase++) begin
      settle();
      case (phase)
        0: c = '{ShortPressMinReset, ShortPressMaxReset, HoldAbortReset,
                 TapMaxMsReset, TapMaxMoveReset, SourceEnableReset};
        1: c = '{'0, '1, '1, '1, '1, '1};
        2: c = '{'0, '0, '0, '0, '0, '1};
        3: c = '{'1, '1, '0, MsW'(1), CoordW'(1), EnW'($urandom_range(0, CoordMax))};
        default: begin
          c.short_press_min_ms = MsW'($urandom_range(0, 200));
          c.short_press_max_ms = MsW'(c.short_press_min_ms + $urandom_range(0, 1500));
          c.hold_abort_ms      = MsW'($urandom_range(0, 6000));
          c.tap_max_ms         = MsW'($urandom_range(0, 1500));
          c.tap_max_move       = CoordW'($urandom_range(0, 60));
          c.source_enable      = EnW'($urandom);
        end
      endcase
      if (phase == NumPhases - 1) begin
        // Closing stretch: everything enabled, no idling on either side.
        c.source_enable = '1;
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = $urandom_range(0, 2) * 15;
        stall_pct = $urandom_range(0, 2) * 15;
      end
      apply_settings(c);

      phase_end = sent + PollsPerPhase;
      while (sent < phase_end) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: power_press();
          4, 5, 6, 7: touch_gesture();
          default: begin
            // Noise: any field, any time.
            repeat ($urandom_range(1, 3)) begin
              poll_at($urandom, 1'($urandom), 1'($urandom),
                      CoordW'($urandom), CoordW'($urandom));
            end
          end
        endcase
      end
    end

    settle();
    repeat (8) @(posedge clk);
    if (mismatches == 0 && outstanding == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
